// File: rtl/mer_pkg.sv
`timescale 1ns / 1ps
package mer_pkg;

  localparam int COORD_BITS  = 10;
  localparam int PIX_BITS    = COORD_BITS + 2;
  localparam int WALK_BITS   = COORD_BITS + 1;
  localparam int SQ_BITS     = 2 * COORD_BITS;
  localparam int SLOPE_BITS  = 3 * COORD_BITS + 2;
  localparam int DEC_BITS    = 4 * COORD_BITS + 8;
  localparam int MUL_A_BITS  = 2 * PIX_BITS;
  localparam int MUL_B_BITS  = SQ_BITS;
  localparam int PROD_BITS   = MUL_A_BITS + MUL_B_BITS;
  localparam int S_DATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int M_DATA_BITS = ((2 * PIX_BITS + 7) / 8) * 8;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_R1,
    PH_R2,
    PH_DONE
  } walk_phase_t;

  typedef enum logic [4:0] {
    ST_READY,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_FIN,
    ST_CHECK,
    ST_E1,
    ST_E2,
    ST_E3,
    ST_E4,
    ST_E5,
    ST_E6,
    ST_R1A,
    ST_R1B,
    ST_R2A,
    ST_R2B,
    ST_EMIT
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_RXRX,
    OP_MUL_RYRY,
    OP_MUL_RX2RY,
    OP_FIN,
    OP_E1,
    OP_E2,
    OP_E3,
    OP_E4,
    OP_E5,
    OP_E6,
    OP_R1A,
    OP_R1B,
    OP_R2A,
    OP_R2B
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       emit;
    logic [1:0] idx;
    logic       done;
  } dp_cmd_t;

  typedef struct packed {
    logic px_lt_py;
    logic wy_zero;
  } dp_status_t;

endpackage

// File: rtl/mer_datapath.sv
`timescale 1ns / 1ps
module mer_datapath
  import mer_pkg::*;
(
  input  logic                  clk,
  input  dp_cmd_t               cmd,
  input  logic [COORD_BITS-1:0] center_x,
  input  logic [COORD_BITS-1:0] center_y,
  input  logic [COORD_BITS-1:0] radius_x,
  input  logic [COORD_BITS-1:0] radius_y,
  output dp_status_t            status,
  output logic [PIX_BITS-1:0]   pixel_x,
  output logic [PIX_BITS-1:0]   pixel_y,
  output logic                  last_of_point,
  output logic                  ellipse_done
);

  logic [COORD_BITS-1:0] ccol, crow, rad_x, rad_y;
  logic [SQ_BITS-1:0]    rx2, ry2;
  logic [WALK_BITS-1:0]  wx, wy;
  logic [SLOPE_BITS-1:0] px, py;
  logic signed [DEC_BITS-1:0] dec;
  logic [PROD_BITS-1:0]  prod;
  logic                  mv;

  logic [MUL_A_BITS-1:0] mul_a;
  logic [MUL_B_BITS-1:0] mul_b;
  logic [PIX_BITS-1:0]   tx;
  logic [WALK_BITS-1:0]  ty;
  logic [DEC_BITS-1:0]   prod4;
  logic [DEC_BITS-1:0]   step_sum;
  logic [SQ_BITS-1:0]    step_sq;
  logic [SLOPE_BITS-1:0] step_px, step_py;
  logic [SLOPE_BITS-1:0] two_rx2, two_ry2;
  logic                  dec_pos;

  assign tx      = {wx, 1'b1};
  assign ty      = wy - 1'b1;
  assign prod4   = DEC_BITS'({prod, 2'b00});
  assign two_rx2 = SLOPE_BITS'({rx2, 1'b0});
  assign two_ry2 = SLOPE_BITS'({ry2, 1'b0});
  assign dec_pos = !dec[DEC_BITS-1] && (dec != '0);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_RXRX: begin
        mul_a = MUL_A_BITS'(rad_x);
        mul_b = MUL_B_BITS'(rad_x);
      end
      OP_MUL_RYRY: begin
        mul_a = MUL_A_BITS'(rad_y);
        mul_b = MUL_B_BITS'(rad_y);
      end
      OP_MUL_RX2RY: begin
        mul_a = MUL_A_BITS'(rad_y);
        mul_b = rx2;
      end
      OP_E1: begin
        mul_a = MUL_A_BITS'(tx);
        mul_b = MUL_B_BITS'(tx);
      end
      OP_E2: begin
        mul_a = prod[MUL_A_BITS-1:0];
        mul_b = ry2;
      end
      OP_E3: begin
        mul_a = MUL_A_BITS'(ty);
        mul_b = MUL_B_BITS'(ty);
      end
      OP_E4: begin
        mul_a = prod[MUL_A_BITS-1:0];
        mul_b = rx2;
      end
      OP_E5: begin
        mul_a = MUL_A_BITS'(rx2);
        mul_b = ry2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // second half of a walk step: sq + px term - py term, scaled by four
  always_comb begin
    if (cmd.op == OP_R1B) begin
      step_sq = ry2;
      step_px = px;
      step_py = mv ? py : '0;
    end else begin
      step_sq = rx2;
      step_px = mv ? '0 : px;
      step_py = py;
    end
    step_sum = DEC_BITS'(step_sq) + DEC_BITS'(step_px) - DEC_BITS'(step_py);
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (cmd.op)
      OP_LOAD: begin
        ccol  <= center_x;
        crow  <= center_y;
        rad_x <= radius_x;
        rad_y <= radius_y;
        wx    <= '0;
        wy    <= WALK_BITS'(radius_y);
        px    <= '0;
      end
      OP_MUL_RYRY:  rx2 <= prod[SQ_BITS-1:0];
      OP_MUL_RX2RY: ry2 <= prod[SQ_BITS-1:0];
      OP_FIN: begin
        py  <= SLOPE_BITS'({prod, 1'b0});
        dec <= DEC_BITS'({ry2, 2'b00}) - prod4 + DEC_BITS'(rx2);
      end
      OP_E3: dec <= DEC_BITS'(prod);
      OP_E5: dec <= dec + prod4;
      OP_E6: dec <= dec - prod4;
      OP_R1A: begin
        wx <= wx + 1'b1;
        px <= px + two_ry2;
        mv <= !dec[DEC_BITS-1];
        if (!dec[DEC_BITS-1]) begin
          wy <= wy - 1'b1;
          py <= py - two_rx2;
        end
      end
      OP_R2A: begin
        wy <= wy - 1'b1;
        py <= py - two_rx2;
        mv <= dec_pos;
        if (!dec_pos) begin
          wx <= wx + 1'b1;
          px <= px + two_ry2;
        end
      end
      OP_R1B, OP_R2B: dec <= dec + {step_sum[DEC_BITS-3:0], 2'b00};
      default: ;
    endcase
  end

  // output beat register, mirrored pixel order +x+y, -x+y, +x-y, -x-y
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_x <= cmd.idx[0] ? PIX_BITS'(ccol) - PIX_BITS'(wx)
                            : PIX_BITS'(ccol) + PIX_BITS'(wx);
      pixel_y <= cmd.idx[1] ? PIX_BITS'(crow) - PIX_BITS'(wy)
                            : PIX_BITS'(crow) + PIX_BITS'(wy);
      last_of_point <= (cmd.idx == 2'd3);
      ellipse_done  <= cmd.done;
    end
  end

  assign status.px_lt_py = (px < py);
  assign status.wy_zero  = (wy == '0);

endmodule

// File: rtl/mer_ctrl.sv
`timescale 1ns / 1ps
module mer_ctrl
  import mer_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_kind,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctl_state_t  state, state_next;
  walk_phase_t phase, phase_next;
  logic [1:0]  idx, idx_next;
  logic        out_valid_next;
  logic        can_load;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_READY;
      phase     <= PH_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    idx_next   = idx;
    case (state)
      ST_READY: begin
        if (in_valid) begin
          if (in_kind == KIND_START) begin
            state_next = ST_MUL1;
          end else if (phase == PH_R1) begin
            state_next = ST_R1A;
          end else if (phase == PH_R2) begin
            state_next = ST_R2A;
          end
        end
      end
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MUL3;
      ST_MUL3: state_next = ST_FIN;
      ST_FIN:  state_next = ST_CHECK;
      ST_CHECK: begin
        idx_next = '0;
        if (status.px_lt_py) begin
          phase_next = PH_R1;
          state_next = ST_EMIT;
        end else if (!status.wy_zero) begin
          state_next = ST_E1;
        end else begin
          phase_next = PH_DONE;
          state_next = ST_EMIT;
        end
      end
      ST_E1: state_next = ST_E2;
      ST_E2: state_next = ST_E3;
      ST_E3: state_next = ST_E4;
      ST_E4: state_next = ST_E5;
      ST_E5: state_next = ST_E6;
      ST_E6: begin
        phase_next = PH_R2;
        state_next = ST_EMIT;
      end
      ST_R1A: state_next = ST_R1B;
      ST_R1B: state_next = ST_CHECK;
      ST_R2A: state_next = ST_R2B;
      ST_R2B: begin
        idx_next   = '0;
        state_next = ST_EMIT;
        if (status.wy_zero) begin
          phase_next = PH_DONE;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          idx_next = idx + 2'd1;
          if (idx == 2'd3) begin
            state_next = ST_READY;
          end
        end
      end
      default: state_next = ST_READY;
    endcase
  end

  always_comb begin
    cmd.op   = OP_NONE;
    cmd.emit = 1'b0;
    cmd.idx  = idx;
    cmd.done = (phase == PH_DONE) && (idx == 2'd3);
    in_ready = 1'b0;
    case (state)
      ST_READY: begin
        in_ready = 1'b1;
        if (in_valid && in_kind == KIND_START) begin
          cmd.op = OP_LOAD;
        end
      end
      ST_MUL1: cmd.op = OP_MUL_RXRX;
      ST_MUL2: cmd.op = OP_MUL_RYRY;
      ST_MUL3: cmd.op = OP_MUL_RX2RY;
      ST_FIN:  cmd.op = OP_FIN;
      ST_E1:   cmd.op = OP_E1;
      ST_E2:   cmd.op = OP_E2;
      ST_E3:   cmd.op = OP_E3;
      ST_E4:   cmd.op = OP_E4;
      ST_E5:   cmd.op = OP_E5;
      ST_E6:   cmd.op = OP_E6;
      ST_R1A:  cmd.op = OP_R1A;
      ST_R1B:  cmd.op = OP_R1B;
      ST_R2A:  cmd.op = OP_R2A;
      ST_R2B:  cmd.op = OP_R2B;
      ST_EMIT: cmd.emit = can_load;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// File: rtl/midpoint_ellipse_rasterizer.sv
`timescale 1ns / 1ps
// channel   dir  tdata (low bit up)                          tuser   tlast
// s_axis    in   center_x, center_y, radius_x, radius_y      kind    -
// m_axis    out  pixel_x, pixel_y (two's complement)         done    last_of_point
//
// Region 1 step: update states R1A and R1B and a check, then 4 pixel beats.
// Region 2 step: update states R2A and R2B, then 4 beats. Start: setup states
// MUL1 to MUL3 on the shared 24x20 multiplier, FIN and CHECK, plus 4 beats;
// region 2 entry adds states E1 to E6. A step with no walk running is dropped.
// rst is synchronous; s_axis_tready drops until all four beats are registered.
module midpoint_ellipse_rasterizer
  import mer_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [S_DATA_BITS-1:0] s_axis_tdata,  // center_x, center_y, radius_x, radius_y
  input  logic                   s_axis_tuser,  // kind
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [M_DATA_BITS-1:0] m_axis_tdata,  // pixel_x, pixel_y
  output logic                   m_axis_tuser,  // ellipse_done
  output logic                   m_axis_tlast   // last_of_point
);

  dp_cmd_t             cmd;
  dp_status_t          status;
  logic [PIX_BITS-1:0] pixel_x, pixel_y;

  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_kind   (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  mer_datapath u_datapath (
    .clk           (clk),
    .cmd           (cmd),
    .center_x      (s_axis_tdata[COORD_BITS-1:0]),
    .center_y      (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .radius_x      (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .radius_y      (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .status        (status),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .last_of_point (m_axis_tlast),
    .ellipse_done  (m_axis_tuser)
  );

  assign m_axis_tdata = M_DATA_BITS'({pixel_y, pixel_x});

endmodule
